@@ rtl/fmbd_pkg.sv @@
// Package for the front/middle/back deque: field widths, operation and status codes.
// Used by the channel interfaces and by the top level; depends on nothing.
package fmbd_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int OPCODE_W         = 3;
    localparam int DATA_W           = 32;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_MIDDLE = 3'd1,
        OP_PUSH_BACK   = 3'd2,
        OP_POP_FRONT   = 3'd3,
        OP_POP_MIDDLE  = 3'd4,
        OP_POP_BACK    = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

@@ rtl/fmbd_req_if.sv @@
// Request channel of the deque: valid/ready handshake carrying opcode and push value.
// Depends on fmbd_pkg.
interface fmbd_req_if;
    import fmbd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [DATA_W-1:0]   push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

@@ rtl/fmbd_rsp_if.sv @@
// Response channel of the deque: valid/ready handshake carrying popped value,
// status and entry count. Depends on fmbd_pkg.
interface fmbd_rsp_if;
    import fmbd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   pop_value;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         entry_count;

    modport source (output valid, output pop_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input entry_count,
                    output ready);
endinterface

@@ rtl/front_middle_back_deque.sv @@
// Bounded deque of signed 32-bit values with push/pop at front, middle and back.
// Depends on fmbd_pkg, fmbd_req_if and fmbd_rsp_if.
//
//   Channel  Direction  Payload
//   req      sink       opcode, push_value
//   rsp      source     pop_value, status, entry_count
//
// One transaction per cycle: every cell of the register array shifts or holds in
// parallel, and the result is loaded into the response register on the same edge.
// A request is taken whenever the response register is empty or is being taken.
// Reset clears the entry count and the response valid flag; entries are not reset.
// A stall on rsp holds the response register and blocks req until it drains.
module front_middle_back_deque #(
    parameter int CAPACITY = fmbd_pkg::DEFAULT_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    fmbd_req_if.sink    req,
    fmbd_rsp_if.source  rsp
);
    import fmbd_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [DATA_W-1:0]  entries_reg  [CAPACITY];
    logic [DATA_W-1:0]  entries_next [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic                       rsp_valid_reg;
    logic [DATA_W-1:0]          pop_value_reg;
    logic [DATA_W-1:0]          pop_value_next;
    status_t                    status_reg;
    status_t                    status_next;
    logic [COUNT_W-1:0]         entry_count_reg;

    logic               req_fire;
    logic               is_full;
    logic               is_empty;
    logic               do_insert;
    logic               do_remove;
    logic [IDX_W-1:0]   pos;
    logic [CNT_W-1:0]   cnt_dec;
    logic [CNT_W-1:0]   cnt_half;
    logic [CNT_W-1:0]   cnt_dec_half;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;

    assign is_full      = (count_reg == CNT_W'(CAPACITY));
    assign is_empty     = (count_reg == '0);
    assign cnt_dec      = count_reg - CNT_W'(1);
    assign cnt_half     = count_reg >> 1;
    assign cnt_dec_half = cnt_dec >> 1;

    always_comb
    begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        pos         = '0;
        status_next = ST_DONE;
        case (opcode_t'(req.opcode))
            OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                    if (opcode_t'(req.opcode) == OP_PUSH_MIDDLE)
                        pos = cnt_half[IDX_W-1:0];
                    else if (opcode_t'(req.opcode) == OP_PUSH_BACK)
                        pos = count_reg[IDX_W-1:0];
                end
            end
            OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_remove = 1'b1;
                    if (opcode_t'(req.opcode) == OP_POP_MIDDLE)
                        pos = cnt_dec_half[IDX_W-1:0];
                    else if (opcode_t'(req.opcode) == OP_POP_BACK)
                        pos = cnt_dec[IDX_W-1:0];
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        pop_value_next = '0;
        if (do_remove)
            pop_value_next = entries_reg[pos];
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
            count_next = count_reg + CNT_W'(1);
        else if (do_remove)
            count_next = cnt_dec;
    end

    // Each cell picks its own value, the pushed value, its lower neighbor's or its upper neighbor's.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [IDX_W-1:0] CELL = IDX_W'(i);

        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (do_insert)
            begin
                if (CELL == pos)
                    entries_next[i] = req.push_value;
                else if (CELL > pos)
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
            end
            else if (do_remove)
            begin
                if ((CELL >= pos) && (i < CAPACITY - 1))
                    entries_next[i] = entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            entries_reg <= entries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
                count_reg <= count_next;
            if (req_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pop_value_reg   <= pop_value_next;
            status_reg      <= status_next;
            entry_count_reg <= COUNT_W'(count_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.pop_value   = pop_value_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule
